[rtl/dsm_pkg.sv]
// Shared types, coefficients and fixed-point helpers for the I/Q delta-sigma modulator.
package dsm_pkg;

  localparam int unsigned SmpW   = 12;  // input sample, 8 fractional bits
  localparam int unsigned LvlW   = 4;   // quantiser level
  localparam int unsigned StW    = 24;  // loop state, 19 fractional bits
  localparam int unsigned AccW   = 40;  // product/sum accumulator, 30 fractional bits
  localparam int unsigned NLanes = 2;

  localparam logic signed [StW-1:0] StMax = 24'sh7FFFFF;
  localparam logic signed [StW-1:0] StMin = -24'sh800000;

  localparam logic signed [LvlW-1:0] LvlMax = 4'sd7;
  localparam logic signed [LvlW-1:0] LvlMin = -4'sd8;

  // Loop filter coefficients, raw signed 12-bit values
  localparam logic signed [11:0] KB00 = 12'sd1888;  // /2^8
  localparam logic signed [11:0] KA01 = 12'sd710;   // /2^11
  localparam logic signed [11:0] KB10 = 12'sd868;   // /2^11
  localparam logic signed [11:0] KA11 = 12'sd1364;  // /2^11
  localparam logic signed [11:0] KB11 = 12'sd1425;  // /2^9
  localparam logic signed [11:0] KA12 = 12'sd333;   // /2^11
  localparam logic signed [11:0] KB20 = 12'sd1179;  // /2^8
  localparam logic signed [11:0] KA21 = 12'sd1278;  // /2^11
  localparam logic signed [11:0] KB21 = 12'sd48;    // /2^11
  localparam logic signed [11:0] KA22 = 12'sd924;   // /2^11

  typedef logic signed [StW-1:0]  state_t;
  typedef logic signed [AccW-1:0] acc_t;
  typedef logic signed [LvlW-1:0] lvl_t;
  typedef logic signed [SmpW-1:0] smp_t;

  // Sequencer strobes to one lane
  typedef struct packed {
    logic load;    // sample accepted: form lane input sum
    logic quant;   // quantise, form error
    logic sect;    // section inputs x0, w1, w2
    logic feed;    // second-order outputs x1, x2
    logic commit;  // update feedback and delay line
  } dsm_ctrl_t;

  function automatic state_t sat_acc(acc_t v);
    if (v > acc_t'(StMax)) begin
      return StMax;
    end else if (v < acc_t'(StMin)) begin
      return StMin;
    end
    return v[StW-1:0];
  endfunction

  // 30 fractional bits down to 19: round half up, saturate
  function automatic state_t to_state(acc_t v);
    acc_t r;
    r = (v + acc_t'(1024)) >>> 11;
    return sat_acc(r);
  endfunction

  function automatic acc_t kmul(logic signed [11:0] k, state_t v);
    acc_t ke;
    acc_t ve;
    ke = acc_t'(k);
    ve = acc_t'(v);
    return ke * ve;
  endfunction

endpackage

[rtl/dsm_if.sv]
// Handshake channel interfaces: sample input, result output and mode register write.
interface dsm_smp_if import dsm_pkg::*; ();
  logic valid;
  logic ready;
  smp_t sample_real;
  smp_t sample_imag;

  modport source (output valid, output sample_real, output sample_imag, input ready);
  modport sink   (input valid, input sample_real, input sample_imag, output ready);
endinterface

interface dsm_res_if import dsm_pkg::*; ();
  logic valid;
  logic ready;
  lvl_t out_real;
  lvl_t out_imag;

  modport source (output valid, output out_real, output out_imag, input ready);
  modport sink   (input valid, input out_real, input out_imag, output ready);
endinterface

interface dsm_cfg_if;
  logic valid;
  logic ready;
  logic complex_mode;

  modport source (output valid, output complex_mode, input ready);
  modport sink   (input valid, input complex_mode, output ready);
endinterface

[rtl/dsm_lane.sv]
// One modulator lane: quantiser, three loop filter sections and feedback state.
module dsm_lane import dsm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dsm_ctrl_t ctrl_i,
  input  smp_t      xin_i,
  output lvl_t      q_o
);

  // loop state
  state_t fb_q, s0_q, s1a_q, s1b_q, s2a_q, s2b_q;
  // working registers
  state_t yi_q, e_q, x0_q, w1_q, w2_q, x1_q, x2_q;
  lvl_t   q_q;

  logic signed [StW:0] sum_in, rnd, err;
  logic signed [5:0]   qw;
  lvl_t                q_d;
  state_t              e_d, x0_d, w1_d, w2_d, x1_d, x2_d, fb_d;

  always_comb begin
    sum_in = {{2{xin_i[SmpW-1]}}, xin_i, 11'b0} + {fb_q[StW-1], fb_q};

    rnd = {yi_q[StW-1], yi_q} + 25'sd262144;
    qw  = rnd[StW:19];
    if (qw > 6'(LvlMax)) begin
      q_d = LvlMax;
    end else if (qw < 6'(LvlMin)) begin
      q_d = LvlMin;
    end else begin
      q_d = qw[LvlW-1:0];
    end
    err = {yi_q[StW-1], yi_q} - {{2{q_d[LvlW-1]}}, q_d, 19'b0};
    e_d = sat_acc(acc_t'(err));

    x0_d = to_state((kmul(KB00, e_q) <<< 3) + kmul(KA01, s0_q));
    w1_d = to_state((acc_t'(e_q) <<< 11) + kmul(KA11, s1a_q) - kmul(KA12, s1b_q));
    w2_d = to_state((acc_t'(e_q) <<< 11) + kmul(KA21, s2a_q) - kmul(KA22, s2b_q));

    x1_d = to_state(kmul(KB10, w1_q) - (kmul(KB11, s1a_q) <<< 2));
    x2_d = to_state(kmul(KB21, s2a_q) - (kmul(KB20, w2_q) <<< 3));

    fb_d = sat_acc(acc_t'(x0_q) + acc_t'(x1_q) + acc_t'(x2_q));
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      yi_q <= sat_acc(acc_t'(sum_in));
    end
    if (ctrl_i.quant) begin
      q_q <= q_d;
      e_q <= e_d;
    end
    if (ctrl_i.sect) begin
      x0_q <= x0_d;
      w1_q <= w1_d;
      w2_q <= w2_d;
    end
    if (ctrl_i.feed) begin
      x1_q <= x1_d;
      x2_q <= x2_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_q  <= '0;
      s0_q  <= '0;
      s1a_q <= '0;
      s1b_q <= '0;
      s2a_q <= '0;
      s2b_q <= '0;
    end else if (ctrl_i.commit) begin
      fb_q  <= fb_d;
      s0_q  <= x0_q;
      s1b_q <= s1a_q;
      s1a_q <= w1_q;
      s2b_q <= s2a_q;
      s2a_q <= w2_q;
    end
  end

  assign q_o = q_q;

endmodule

[rtl/dsm_merge.sv]
// Merges the lane levels into one result item and holds it in the output register.
module dsm_merge import dsm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  lvl_t      q_re_i,
  input  lvl_t      q_im_i,
  input  logic      mode_i,
  output logic      free_o,
  dsm_res_if.source res_o
);

  logic valid_q;
  lvl_t re_q, im_q;

  assign free_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (res_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  // imaginary level reads zero in real mode
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      re_q <= q_re_i;
      im_q <= mode_i ? q_im_i : '0;
    end
  end

  assign res_o.valid    = valid_q;
  assign res_o.out_real = re_q;
  assign res_o.out_imag = im_q;

  a_real_mode_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !mode_i |=> res_o.out_imag == '0)
    else $error("imaginary level not zero in real mode");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> free_o)
    else $error("result pushed over an untaken item");

endmodule

[rtl/delta_sigma_modulator_iq.sv]
// Top level of the two-lane I/Q delta-sigma modulator with 4-bit quantiser.
// The result item is registered at commit, after the sample item has passed the quantise, section and feed
// states; commit waits while the output register is full. A new sample is accepted only once the last has gone
//   through each lane's feedback loop (input sum, quantiser, section inputs, second products, commit).
// Reset (rst_ni low, async): loop state of both lanes zero, real mode, no item held.
// Mode register writes are always taken; the sample input is ready only when idle.
module delta_sigma_modulator_iq import dsm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  dsm_smp_if.sink   smp_i,
  dsm_cfg_if.sink   cfg_i,
  dsm_res_if.source res_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_QUANT,
    S_SECT,
    S_FEED,
    S_COMMIT
  } state_e;

  state_e    state_q;
  logic      mode_q;
  logic      accept;
  logic      out_free;
  logic      push;
  dsm_ctrl_t ctrl_re, ctrl_im;
  lvl_t      q_re, q_im;

  assign cfg_i.ready = 1'b1;
  assign smp_i.ready = (state_q == S_IDLE);
  assign accept      = smp_i.valid && smp_i.ready;

  // Commit waits for the output register; lane state and result move together.
  assign push = (state_q == S_COMMIT) && out_free;

  always_comb begin
    ctrl_re.load   = accept;
    ctrl_re.quant  = (state_q == S_QUANT);
    ctrl_re.sect   = (state_q == S_SECT);
    ctrl_re.feed   = (state_q == S_FEED);
    ctrl_re.commit = push;
    // imaginary lane holds its state in real mode
    ctrl_im        = ctrl_re;
    ctrl_im.commit = push && mode_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        mode_q <= cfg_i.complex_mode;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_QUANT;
          end
        end
        S_QUANT:  state_q <= S_SECT;
        S_SECT:   state_q <= S_FEED;
        S_FEED:   state_q <= S_COMMIT;
        S_COMMIT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default:  state_q <= S_IDLE;
      endcase
    end
  end

  // Real lane
  dsm_lane u_lane_re (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl_re),
    .xin_i  (smp_i.sample_real),
    .q_o    (q_re)
  );

  // Imaginary lane
  dsm_lane u_lane_im (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl_im),
    .xin_i  (smp_i.sample_imag),
    .q_o    (q_im)
  );

  // Merge both levels into the output item
  dsm_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .q_re_i (q_re),
    .q_im_i (q_im),
    .mode_i (mode_q),
    .free_o (out_free),
    .res_o  (res_o)
  );

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_QUANT)
    else $error("accepted item did not start the sequence");

  a_commit_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_COMMIT && !out_free |=> state_q == S_COMMIT)
    else $error("commit left while output register was full");

  a_result_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(state_q == S_COMMIT))
    else $error("result appeared outside commit");

endmodule

[test/testbench.sv]
// Self-checking testbench for the two-lane I/Q delta-sigma modulator.
`timescale 1ns / 1ps

module testbench import dsm_pkg::*; ();

  // Mode register codes
  localparam logic ModeReal    = 1'b0;
  localparam logic ModeComplex = 1'b1;

  // Cycles without any accepted item before the run is abandoned. The longest
  // legitimate quiet spell is the output hold-off (HoldCycles) plus a sender gap.
  localparam int StallLimit = 2000;
  localparam int HoldCycles = 150;

  // Loop filter coefficients, raw 12-bit values (scales noted alongside)
  localparam longint CB00 = 1888;  // /2^8
  localparam longint CA01 = 710;   // /2^11
  localparam longint CB10 = 868;   // /2^11
  localparam longint CA11 = 1364;  // /2^11
  localparam longint CB11 = 1425;  // /2^9
  localparam longint CA12 = 333;   // /2^11
  localparam longint CB20 = 1179;  // /2^8
  localparam longint CA21 = 1278;  // /2^11
  localparam longint CB21 = 48;    // /2^11
  localparam longint CA22 = 924;   // /2^11

  localparam longint StateHi = 64'sd8388607;
  localparam longint StateLo = -64'sd8388608;

  typedef struct packed {
    lvl_t re;
    lvl_t im;
  } level_pair_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  dsm_smp_if smp_if ();
  dsm_cfg_if cfg_if ();
  dsm_res_if res_if ();

  delta_sigma_modulator_iq DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .smp_i  (smp_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Loop state of the predictor, index 0 real lane, 1 imaginary lane
  longint feedback_st[2];
  longint sec0_st[2];
  longint sec1_d1[2];
  longint sec1_d2[2];
  longint sec2_d1[2];
  longint sec2_d2[2];
  logic   mode_model;

  level_pair_t expected_levels[$];

  int failures;
  int results_checked;
  int items_real;
  int items_cplx;
  int mode_writes;
  int quiet_cycles;

  // Output-side idling: random stall bursts, a long hold-off on request,
  // and none at all once the steady part starts.
  bit steady;
  int hold_request;
  int hold_left;
  int stall_left;

  // Corner samples: zero, both extremes, +/- one LSB, alternating bits, half scale
  int corner_vals[8] = '{0, 2047, -2048, 1, -1, 1365, -1366, 1024};

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic longint clip_state(longint v);
    if (v > StateHi) return StateHi;
    if (v < StateLo) return StateLo;
    return v;
  endfunction

  // v / 2^s rounded half up (floor of v/2^s + 1/2)
  function automatic longint round_up_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // 30 fractional bits down to 19, rounded and saturated
  function automatic longint narrow_state(longint v);
    return clip_state(round_up_shift(v, 11));
  endfunction

  // One sample through one lane's loop; updates that lane's state
  function automatic lvl_t lane_level(int ln, longint smp);
    longint acc_in, lvl, err, x0, w1, x1, w2, x2;
    acc_in = clip_state(smp * 2048 + feedback_st[ln]);
    lvl = round_up_shift(acc_in, 19);
    if (lvl > 7) lvl = 7;
    else if (lvl < -8) lvl = -8;
    err = clip_state(acc_in - lvl * 524288);

    x0 = narrow_state(CB00 * err * 8 + CA01 * sec0_st[ln]);
    w1 = narrow_state(err * 2048 + CA11 * sec1_d1[ln] - CA12 * sec1_d2[ln]);
    x1 = narrow_state(CB10 * w1 - CB11 * sec1_d1[ln] * 4);
    w2 = narrow_state(err * 2048 + CA21 * sec2_d1[ln] - CA22 * sec2_d2[ln]);
    x2 = narrow_state(CB21 * sec2_d1[ln] - CB20 * w2 * 8);

    feedback_st[ln] = clip_state(x0 + x1 + x2);
    sec0_st[ln] = x0;
    sec1_d2[ln] = sec1_d1[ln];
    sec1_d1[ln] = w1;
    sec2_d2[ln] = sec2_d1[ln];
    sec2_d1[ln] = w2;
    return lvl_t'(lvl);
  endfunction

  // Imaginary lane is frozen in real mode and its level reads zero
  function automatic void predict_levels(smp_t re, smp_t im);
    level_pair_t lv;
    lv.re = lane_level(0, longint'(re));
    lv.im = '0;
    if (mode_model == ModeComplex) begin
      lv.im = lane_level(1, longint'(im));
      items_cplx++;
    end else begin
      items_real++;
    end
    expected_levels.insert(expected_levels.size(), lv);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest expectation
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    level_pair_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_levels.size() == 0) begin
        $display("%0t: result item with nothing expected, got re %0d im %0d",
                 $time, res_if.out_real, res_if.out_imag);
        failures++;
      end else begin
        want = expected_levels.pop_front();
        results_checked++;
        if (res_if.out_real !== want.re) begin
          $display("%0t: out_real mismatch, expected %0d, got %0d",
                   $time, want.re, res_if.out_real);
          failures++;
        end
        if (res_if.out_imag !== want.im) begin
          $display("%0t: out_imag mismatch, expected %0d, got %0d",
                   $time, want.im, res_if.out_imag);
          failures++;
        end
      end
    end
  end

  // Output ready, changed on the falling edge
  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      res_if.ready = 1'b0;
      hold_left--;
    end else if (steady) begin
      res_if.ready = 1'b1;
    end else if (stall_left != 0) begin
      res_if.ready = 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      res_if.ready = 1'b0;
    end else begin
      res_if.ready = 1'b1;
    end
  end

  // Watchdog: gives up after a long spell with no handshake anywhere
  always @(posedge clk_i) begin
    if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding",
                 $time, StallLimit, expected_levels.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared driving tasks; each starts and ends on a falling edge
  // ---------------------------------------------------------------------------

  task automatic send_sample(input smp_t re, input smp_t im);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 19);
    if (gap != 0) begin
      smp_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    smp_if.valid = 1'b1;
    smp_if.sample_real = re;
    smp_if.sample_imag = im;
    do @(posedge clk_i); while (!smp_if.ready);
    predict_levels(re, im);
    @(negedge clk_i);
  endtask

  // Stop offering and let every outstanding result come out
  task automatic wait_all_levels();
    smp_if.valid = 1'b0;
    while (expected_levels.size() != 0) @(negedge clk_i);
  endtask

  // Mode writes only with the block idle: every outstanding result is taken
  // and the bench then waits on spare falling edges before touching the register
  task automatic write_mode(input logic mode);
    wait_all_levels();
    repeat (8) @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.complex_mode = mode;
    do @(posedge clk_i); while (!cfg_if.ready);
    mode_model = mode;
    mode_writes++;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Real mode straight out of reset: corners on the real lane, the
  // imaginary field carries corners too but must be ignored
  task automatic test_real_extremes();
    for (int k = 0; k < 8; k++)
      send_sample(smp_t'(corner_vals[k]), smp_t'(corner_vals[7 - k]));
  endtask

  // Both lanes live; imaginary lane starts from its untouched reset state
  task automatic test_complex_extremes();
    write_mode(ModeComplex);
    for (int k = 0; k < 8; k++)
      send_sample(smp_t'(corner_vals[7 - k]), smp_t'(corner_vals[k]));
  endtask

  // Full-scale drive past the quantiser range: sums, error and sections saturate
  task automatic test_overload();
    for (int k = 0; k < 8; k++)
      send_sample(smp_t'(2047), smp_t'(-2048));
  endtask

  // Phases in real and complex mode, complex in two of every three; state carries across each switch.
  // Styles: uniform noise, slow random walk, near-full-scale level with random jitter.
  task automatic test_mode_phases();
    int walk_re, walk_im, base_re, base_im, style;
    logic mode;
    for (int p = 0; p < 8; p++) begin
      mode = (p % 3 == 1) ? ModeReal : ModeComplex;
      write_mode(mode);
      style = p % 3;
      walk_re = 0;
      walk_im = 0;
      base_re = $urandom_range(0, 1) ? 1900 : -1900;
      base_im = $urandom_range(0, 1) ? 1900 : -1900;
      for (int k = 0; k < 140; k++) begin
        if (style == 0 || $urandom_range(0, 9) == 0) begin
          send_sample(smp_t'($urandom), smp_t'($urandom));
        end else if (style == 1) begin
          walk_re += int'($urandom_range(0, 96)) - 48;
          walk_im += int'($urandom_range(0, 96)) - 48;
          if (walk_re > 1900) walk_re = 1900;
          if (walk_re < -1900) walk_re = -1900;
          if (walk_im > 1900) walk_im = 1900;
          if (walk_im < -1900) walk_im = -1900;
          send_sample(smp_t'(walk_re), smp_t'(walk_im));
        end else begin
          send_sample(smp_t'(base_re + int'($urandom_range(0, 255)) - 128),
                      smp_t'(base_im + int'($urandom_range(0, 255)) - 128));
        end
      end
    end
  endtask

  // Output held off for a long stretch while samples keep being offered,
  // so the block fills and drops its input ready
  task automatic test_output_backpressure();
    write_mode(ModeComplex);
    hold_request = HoldCycles;
    for (int k = 0; k < 30; k++)
      send_sample(smp_t'($urandom), smp_t'($urandom));
  endtask

  // Closing stretch with no idling on either side
  task automatic test_steady_stream();
    write_mode(ModeReal);
    steady = 1'b1;
    for (int k = 0; k < 60; k++)
      send_sample(smp_t'($urandom), smp_t'($urandom));
    write_mode(ModeComplex);
    for (int k = 0; k < 120; k++)
      send_sample(smp_t'($urandom), smp_t'($urandom));
  endtask

  initial begin
    smp_if.valid = 1'b0;
    smp_if.sample_real = '0;
    smp_if.sample_imag = '0;
    cfg_if.valid = 1'b0;
    cfg_if.complex_mode = ModeReal;
    res_if.ready = 1'b0;
    steady = 1'b0;
    hold_request = 0;
    hold_left = 0;
    stall_left = 0;
    failures = 0;
    results_checked = 0;
    items_real = 0;
    items_cplx = 0;
    mode_writes = 0;
    quiet_cycles = 0;
    mode_model = ModeReal;
    for (int ln = 0; ln < 2; ln++) begin
      feedback_st[ln] = 0;
      sec0_st[ln] = 0;
      sec1_d1[ln] = 0;
      sec1_d2[ln] = 0;
      sec2_d1[ln] = 0;
      sec2_d2[ln] = 0;
    end

    // Reset held from time zero, released on a falling edge
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_real_extremes();
    test_complex_extremes();
    test_overload();
    test_mode_phases();
    test_output_backpressure();
    test_steady_stream();

    wait_all_levels();
    repeat (10) @(posedge clk_i);

    $display("Sent %0d samples in real mode and %0d in complex mode over %0d mode writes;",
             items_real, items_cplx, mode_writes);
    $display("%0d result items compared, with random stalls and one long output hold-off.",
             results_checked);
    if (failures == 0 && expected_levels.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
